### src/sbcpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcpu_pkg
// Opcodes, item codes, flag positions and sequencer states of the 16-bit core.
// ----------------------------------------------------------------------------
package sbcpu_pkg;

  localparam int INSTR_BYTES = 4;

  localparam int FLAG_O = 0;
  localparam int FLAG_C = 1;
  localparam int FLAG_Z = 2;
  localparam int FLAG_S = 3;

  typedef enum logic [1:0] {
    ITEM_EXEC = 2'd0,
    ITEM_LOAD = 2'd1,
    ITEM_TICK = 2'd2
  } item_op_e;

  typedef enum logic [7:0] {
    OP_NOP     = 8'h00, OP_INPUT   = 8'h01, OP_CALL    = 8'h02, OP_RET     = 8'h03,
    OP_LOAD    = 8'h04, OP_LOADI   = 8'h05, OP_MOV     = 8'h06, OP_MOVI    = 8'h07,
    OP_PUSH    = 8'h08, OP_POP     = 8'h09, OP_ADD     = 8'h0a, OP_SUB     = 8'h0b,
    OP_MUL     = 8'h0c, OP_DIV     = 8'h0d, OP_AND     = 8'h0e, OP_OR      = 8'h0f,
    OP_XOR     = 8'h10, OP_SHL     = 8'h11, OP_SHRA    = 8'h12, OP_SHRL    = 8'h13,
    OP_CMP     = 8'h14, OP_TST     = 8'h15, OP_COLOR   = 8'h16, OP_PIXEL   = 8'h17,
    OP_STOR    = 8'h18, OP_STORI   = 8'h19, OP_TIME    = 8'h1a, OP_TIMERST = 8'h1b,
    OP_RND     = 8'h1c, OP_JMP     = 8'h1d, OP_JMPI    = 8'h1e, OP_JEQ     = 8'h1f,
    OP_JNE     = 8'h20, OP_JG      = 8'h21, OP_JGE     = 8'h22, OP_JA      = 8'h23,
    OP_JAE     = 8'h24, OP_JL      = 8'h25, OP_JLE     = 8'h26, OP_JB      = 8'h27,
    OP_JBE     = 8'h28, OP_JO      = 8'h29, OP_JNO     = 8'h2a, OP_JS      = 8'h2b,
    OP_JNS     = 8'h2c
  } opcode_e;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_F0    = 12'b0000_0000_0100,
    S_F1    = 12'b0000_0000_1000,
    S_F2    = 12'b0000_0001_0000,
    S_F3    = 12'b0000_0010_0000,
    S_F4    = 12'b0000_0100_0000,
    S_EX    = 12'b0000_1000_0000,
    S_M1    = 12'b0001_0000_0000,
    S_M2    = 12'b0010_0000_0000,
    S_DIV   = 12'b0100_0000_0000,
    S_WB    = 12'b1000_0000_0000
  } state_e;

endpackage

### src/sixteen_bit_cpu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_core
// 16-bit processor: byte memory, register file in RAM, one instruction a step.
//
//   channel | handshake               | payload
//   in      | in_valid_i / in_ready_o | op, load_address, load_byte,
//           |                         | input_lines, random_value
//   out     | out_valid_o/out_ready_i | pixel_valid, pixel_x, pixel_y,
//           |                         | pixel_color, next_address
//
// After reset a clearing pass writes zero to all MEMORY_BYTES memory bytes,
// one a cycle; no item is taken until it ends.
// Load and tick items finish in the accepting cycle. A step passes through
// the fetch states and EX; ALU instructions add write-back (DIV also a divide
// state unless dividing by zero), push, call, pop, return and byte loads add memory
// states: the four instruction bytes and the operands come through single read ports serially.
// A new item is taken only when the previous result has left the output.
// ----------------------------------------------------------------------------
module sixteen_bit_cpu_core #(
  parameter int MEMORY_BYTES    = 65536,
  parameter int STACK_REG_INDEX = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] load_address_i,
  input  logic [7:0]  load_byte_i,
  input  logic [15:0] input_lines_i,
  input  logic [15:0] random_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        pixel_valid_o,
  output logic [15:0] pixel_x_o,
  output logic [15:0] pixel_y_o,
  output logic [7:0]  pixel_color_o,
  output logic [15:0] next_address_o
);
  import sbcpu_pkg::*;

  localparam int             AW       = $clog2(MEMORY_BYTES);
  localparam logic [3:0]     SP_IDX   = 4'(STACK_REG_INDEX);
  localparam logic [AW-1:0]  CLR_LAST = AW'(MEMORY_BYTES - 1);

  // byte address modulo memory size; quotient stays below 64
  function automatic logic [AW-1:0] maddr(input logic [15:0] a);
    logic [23:0] v;
    v = {8'b0, a};
    for (int i = 5; i >= 0; i--) begin
      if (v >= (24'(MEMORY_BYTES) << i)) v = v - (24'(MEMORY_BYTES) << i);
    end
    return v[AW-1:0];
  endfunction

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [15:0]   ip_q, ms_q;
  logic [7:0]    color_q;
  logic [3:0]    flags_q;
  logic          out_valid_q;
  logic [15:0]   rf_valid_q;

  logic [7:0]  opc_q, a_q, b_q, c_q, hi_q;
  logic [15:0] d_q, s_q, sp_q, lines_q, rnd_q, sra_q;
  logic [31:0] res_q;
  logic [15:0] div_q;
  logic [16:0] rem_q;
  logic [3:0]  div_cnt_q;
  logic        rf_rd_valid_q;
  logic        pix_valid_q;
  logic [15:0] pix_x_q, pix_y_q;
  logic [7:0]  pix_color_q;

  logic          mem_we;
  logic [15:0]   mem_addr16;
  logic [7:0]    mem_wdata, mem_rdata;
  logic [AW-1:0] mem_addr;
  logic          rf_we;
  logic [3:0]    rf_waddr, rf_raddr;
  logic [15:0]   rf_wdata, rf_q, rf_rd;
  logic          fin, fin_pix;
  logic [15:0]   fin_nip;

  logic        accept, is_alu, take;
  logic [15:0] ip_plus4, arg_a, arg_b, sp_push, sp_pop, pop_val;
  logic [3:0]  r1;
  logic [4:0]  sh;
  logic [3:0]  sk;
  logic [16:0] rem_sh, rem_n;
  logic        div_ge;
  logic [15:0] div_n;
  logic [3:0]  wb_flags;
  logic        dn, sn, rn;

  assign accept   = in_valid_i && in_ready_o;
  assign ip_plus4 = ip_q + 16'(INSTR_BYTES);
  assign arg_a    = {a_q, b_q};
  assign arg_b    = {b_q, c_q};
  assign r1       = a_q[3:0];
  assign rf_rd    = rf_rd_valid_q ? rf_q : 16'h0;
  assign sp_push  = rf_rd + 16'd2;
  assign sp_pop   = rf_rd - 16'd2;
  assign pop_val  = {hi_q, mem_rdata};
  assign is_alu   = opc_q inside {[OP_ADD:OP_TST]};
  assign sh       = (s_q > 16'd16) ? 5'd16 : s_q[4:0];
  assign sk       = (sh > 5'd15) ? 4'd15 : sh[3:0];
  assign mem_addr = (state_q == S_CLEAR) ? clr_q : maddr(mem_addr16);

  // restoring divider step
  assign rem_sh = {rem_q[15:0], div_q[15]};
  assign div_ge = rem_sh >= {1'b0, s_q};
  assign rem_n  = div_ge ? rem_sh - {1'b0, s_q} : rem_sh;
  assign div_n  = {div_q[14:0], div_ge};

  assign dn = d_q[15];
  assign sn = s_q[15];
  assign rn = res_q[15];
  always_comb begin
    wb_flags         = '0;
    wb_flags[FLAG_C] = |res_q[31:16];
    wb_flags[FLAG_Z] = res_q[15:0] == 16'h0;
    wb_flags[FLAG_S] = rn;
    if (opc_q == OP_ADD) begin
      wb_flags[FLAG_O] = (dn && sn && !rn) || (!dn && !sn && rn);
    end else if (opc_q == OP_SUB || opc_q == OP_CMP) begin
      wb_flags[FLAG_O] = (dn && !sn && !rn) || (!dn && sn && rn);
    end
  end

  always_comb begin
    case (opc_q)
      OP_JMPI: take = 1'b1;
      OP_JEQ:  take = flags_q[FLAG_Z];
      OP_JNE:  take = !flags_q[FLAG_Z];
      OP_JG:   take = !flags_q[FLAG_Z] && (flags_q[FLAG_S] == flags_q[FLAG_O]);
      OP_JGE:  take = flags_q[FLAG_S] == flags_q[FLAG_O];
      OP_JA:   take = !flags_q[FLAG_C] && !flags_q[FLAG_Z];
      OP_JAE:  take = !flags_q[FLAG_C];
      OP_JL:   take = flags_q[FLAG_S] != flags_q[FLAG_O];
      OP_JLE:  take = (flags_q[FLAG_S] != flags_q[FLAG_O]) || flags_q[FLAG_Z];
      OP_JB:   take = flags_q[FLAG_C];
      OP_JBE:  take = flags_q[FLAG_C] || flags_q[FLAG_Z];
      OP_JO:   take = flags_q[FLAG_O];
      OP_JNO:  take = !flags_q[FLAG_O];
      OP_JS:   take = flags_q[FLAG_S];
      OP_JNS:  take = !flags_q[FLAG_S];
      default: take = 1'b0;
    endcase
  end

  // sequencer: memory and register file accesses, completion
  always_comb begin
    state_d    = state_q;
    mem_we     = 1'b0;
    mem_addr16 = ip_q;
    mem_wdata  = 8'h0;
    rf_we      = 1'b0;
    rf_waddr   = r1;
    rf_wdata   = 16'h0;
    rf_raddr   = SP_IDX;
    fin        = 1'b0;
    fin_nip    = ip_plus4;
    fin_pix    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_q == CLR_LAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            ITEM_EXEC: state_d = S_F0;
            ITEM_LOAD: begin
              mem_we     = 1'b1;
              mem_addr16 = load_address_i;
              mem_wdata  = load_byte_i;
              fin        = 1'b1;
              fin_nip    = ip_q;
            end
            default: begin
              fin     = 1'b1;
              fin_nip = ip_q;
            end
          endcase
        end
      end
      S_F0: state_d = S_F1;
      S_F1: begin
        mem_addr16 = ip_q + 16'd1;
        state_d    = S_F2;
      end
      S_F2: begin
        mem_addr16 = ip_q + 16'd2;
        rf_raddr   = mem_rdata[3:0];
        state_d    = S_F3;
      end
      S_F3: begin
        mem_addr16 = ip_q + 16'd3;
        rf_raddr   = mem_rdata[3:0];
        state_d    = S_F4;
      end
      S_F4: state_d = S_EX;
      S_EX: begin
        if (is_alu) begin
          state_d = (opc_q == OP_DIV && s_q != 16'h0) ? S_DIV : S_WB;
        end else begin
          case (opc_q)
            OP_INPUT: begin
              rf_we    = 1'b1;
              rf_wdata = (s_q < 16'd16) ? {15'b0, lines_q[s_q[3:0]]} : 16'h0;
              fin      = 1'b1;
            end
            OP_CALL, OP_PUSH: begin
              rf_we      = 1'b1;
              rf_waddr   = SP_IDX;
              rf_wdata   = sp_push;
              mem_we     = 1'b1;
              mem_addr16 = sp_push;
              mem_wdata  = (opc_q == OP_CALL) ? ip_q[15:8] : d_q[15:8];
              state_d    = S_M1;
            end
            OP_RET, OP_POP: begin
              rf_we      = 1'b1;
              rf_waddr   = SP_IDX;
              rf_wdata   = sp_pop;
              mem_addr16 = rf_rd;
              state_d    = S_M1;
            end
            OP_LOAD: begin
              mem_addr16 = s_q;
              state_d    = S_M1;
            end
            OP_LOADI: begin
              mem_addr16 = arg_b;
              state_d    = S_M1;
            end
            OP_MOV: begin
              rf_we    = 1'b1;
              rf_wdata = s_q;
              fin      = 1'b1;
            end
            OP_MOVI: begin
              rf_we    = 1'b1;
              rf_wdata = arg_b;
              fin      = 1'b1;
            end
            OP_PIXEL: begin
              fin_pix = 1'b1;
              fin     = 1'b1;
            end
            OP_STOR, OP_STORI: begin
              mem_we     = 1'b1;
              mem_addr16 = (opc_q == OP_STOR) ? s_q : arg_b;
              mem_wdata  = d_q[7:0];
              fin        = 1'b1;
            end
            OP_TIME: begin
              rf_we    = 1'b1;
              rf_wdata = ms_q;
              fin      = 1'b1;
            end
            OP_RND: begin
              rf_we    = 1'b1;
              rf_wdata = rnd_q;
              fin      = 1'b1;
            end
            OP_JMP: begin
              fin_nip = d_q;
              fin     = 1'b1;
            end
            default: begin
              if (take) fin_nip = arg_a;
              fin = 1'b1;
            end
          endcase
        end
      end
      S_M1: begin
        case (opc_q)
          OP_CALL, OP_PUSH: begin
            mem_we     = 1'b1;
            mem_addr16 = sp_q + 16'd1;
            mem_wdata  = (opc_q == OP_CALL) ? ip_q[7:0] : d_q[7:0];
            if (opc_q == OP_CALL) fin_nip = arg_a;
            fin = 1'b1;
          end
          OP_RET, OP_POP: begin
            mem_addr16 = sp_q + 16'd1;
            state_d    = S_M2;
          end
          default: begin
            rf_we    = 1'b1;
            rf_wdata = {8'h0, mem_rdata};
            fin      = 1'b1;
          end
        endcase
      end
      S_M2: begin
        if (opc_q == OP_RET) begin
          fin_nip = pop_val + {8'h0, a_q} + 16'(INSTR_BYTES);
        end else begin
          rf_we    = 1'b1;
          rf_wdata = pop_val;
        end
        fin = 1'b1;
      end
      S_DIV: begin
        if (div_cnt_q == 4'hf) state_d = S_WB;
      end
      S_WB: begin
        rf_we    = (opc_q != OP_CMP) && (opc_q != OP_TST);
        rf_wdata = (opc_q == OP_SHRA) ? sra_q : res_q[15:0];
        fin      = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
    if (fin) state_d = S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      ip_q        <= 16'h0;
      ms_q        <= 16'h0;
      color_q     <= 8'h0;
      flags_q     <= 4'h0;
      out_valid_q <= 1'b0;
      rf_valid_q  <= 16'h0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if (rf_we) rf_valid_q[rf_waddr] <= 1'b1;
      if (accept && op_i == ITEM_TICK) ms_q <= ms_q + 16'd1;
      if (state_q == S_EX && !is_alu) begin
        flags_q <= 4'h0;
        if (opc_q == OP_COLOR) color_q <= d_q[7:0];
        if (opc_q == OP_TIMERST) ms_q <= 16'h0;
      end
      if (state_q == S_WB) flags_q <= wb_flags;
      if (fin) begin
        out_valid_q <= 1'b1;
        ip_q        <= {fin_nip[15:2], 2'b00};
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rf_rd_valid_q <= rf_valid_q[rf_raddr];
    if (accept) begin
      lines_q <= input_lines_i;
      rnd_q   <= random_value_i;
    end
    case (state_q)
      S_F1: opc_q <= mem_rdata;
      S_F2: a_q   <= mem_rdata;
      S_F3: begin
        b_q <= mem_rdata;
        d_q <= rf_rd;
      end
      S_F4: begin
        c_q <= mem_rdata;
        s_q <= rf_rd;
      end
      S_EX: begin
        sp_q      <= (opc_q == OP_CALL || opc_q == OP_PUSH) ? sp_push : rf_rd;
        sra_q     <= 16'($signed(d_q) >>> sk);
        div_q     <= d_q;
        rem_q     <= 17'h0;
        div_cnt_q <= 4'h0;
        case (opc_q)
          OP_ADD:           res_q <= {16'h0, d_q} + {16'h0, s_q};
          OP_SUB, OP_CMP:   res_q <= {16'h0, d_q} - {16'h0, s_q};
          OP_MUL:           res_q <= 32'(d_q) * 32'(s_q);
          OP_DIV:           res_q <= 32'h0000_ffff;
          OP_AND, OP_TST:   res_q <= {16'h0, d_q & s_q};
          OP_OR:            res_q <= {16'h0, d_q | s_q};
          OP_XOR:           res_q <= {16'h0, d_q ^ s_q};
          OP_SHL:           res_q <= {16'h0, d_q} << sh;
          OP_SHRA, OP_SHRL: res_q <= {16'h0, d_q} >> sh;
          default:          res_q <= 32'h0;
        endcase
      end
      S_M1: hi_q <= mem_rdata;
      S_DIV: begin
        rem_q     <= rem_n;
        div_q     <= div_n;
        div_cnt_q <= div_cnt_q + 4'd1;
        if (div_cnt_q == 4'hf) res_q <= {16'h0, div_n};
      end
      default: ;
    endcase
    if (fin) begin
      pix_valid_q <= fin_pix;
      pix_x_q     <= fin_pix ? d_q : 16'h0;
      pix_y_q     <= fin_pix ? s_q : 16'h0;
      pix_color_q <= fin_pix ? color_q : 8'h0;
    end
  end

  sbcpu_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  sbcpu_ram #(.WIDTH(16), .DEPTH(16)) u_regs (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr),
    .rdata_o (rf_q)
  );

  assign in_ready_o     = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign pixel_valid_o  = pix_valid_q;
  assign pixel_x_o      = pix_x_q;
  assign pixel_y_o      = pix_y_q;
  assign pixel_color_o  = pix_color_q;
  assign next_address_o = ip_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_ip_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ip_q[1:0] == 2'b00)
    else $error("instruction pointer not aligned");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !out_valid_q && !rf_we)
    else $error("activity during memory clear");

  a_idle_no_rf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !rf_we)
    else $error("register write while idle");

endmodule

### src/sbcpu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcpu_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbcpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Loads short programs into the core, steps them and compares every result
// item with a cycle-free model of the core kept inside this bench.
// ----------------------------------------------------------------------------
module tb_top;
  import sbcpu_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] lines;
    logic [15:0] rnd;
    bit          hold;
  } cmd_t;

  typedef struct {
    logic        pv;
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  pc;
    logic [15:0] na;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [15:0] load_address_i = '0;
  logic [7:0]  load_byte_i = '0;
  logic [15:0] input_lines_i = '0;
  logic [15:0] random_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        pixel_valid_o;
  logic [15:0] pixel_x_o;
  logic [15:0] pixel_y_o;
  logic [7:0]  pixel_color_o;
  logic [15:0] next_address_o;

  sixteen_bit_cpu_core dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // core model state
  logic [15:0] m_regs [16];
  logic [7:0]  m_mem [65536];
  logic [15:0] m_ip;
  logic [7:0]  m_color;
  logic [3:0]  m_flags;
  logic [15:0] m_ms;

  cmd_t pending_q[$];
  res_t expected_q[$];
  int   n_sent = 0;
  int   n_got = 0;
  int   n_errors = 0;
  bit   calm = 1'b0;
  bit   gen_done = 1'b0;

  function automatic void push_word(logic [15:0] v);
    logic [15:0] sp;
    sp = m_regs[15] + 16'd2;
    m_regs[15] = sp;
    m_mem[sp] = v[15:8];
    m_mem[sp + 16'd1] = v[7:0];
  endfunction

  function automatic logic [15:0] pop_word();
    logic [15:0] sp;
    sp = m_regs[15];
    m_regs[15] = sp - 16'd2;
    return {m_mem[sp], m_mem[sp + 16'd1]};
  endfunction

  function automatic res_t core_step(cmd_t c);
    res_t r;
    logic [7:0]  opc, a, b, cc;
    logic [15:0] arg_a, arg_b, nip, v;
    logic [31:0] d, s, res, sh, k;
    logic [3:0]  r1, r2;
    bit alu, take, fo, fc, fz, fs;
    int kind;
    r = '{default: '0};
    if (c.op == ITEM_LOAD) begin
      m_mem[c.addr] = c.data;
    end else if (c.op == ITEM_TICK) begin
      m_ms = m_ms + 16'd1;
    end else if (c.op == ITEM_EXEC) begin
      opc = m_mem[m_ip];
      a = m_mem[m_ip + 16'd1];
      b = m_mem[m_ip + 16'd2];
      cc = m_mem[m_ip + 16'd3];
      r1 = a[3:0];
      r2 = b[3:0];
      arg_a = {a, b};
      arg_b = {b, cc};
      d = {16'd0, m_regs[r1]};
      s = {16'd0, m_regs[r2]};
      sh = (s > 16) ? 32'd16 : s;
      nip = m_ip + 16'd4;
      alu = 1'b1;
      take = 1'b0;
      kind = 0;
      res = '0;
      {fs, fz, fc, fo} = m_flags;
      case (opcode_e'(opc))
        OP_ADD:  begin res = d + s; kind = 1; end
        OP_SUB:  begin res = d - s; kind = 2; end
        OP_MUL:  res = d * s;
        OP_DIV:  res = (s != 0) ? d / s : 32'hffff;
        OP_AND:  res = d & s;
        OP_OR:   res = d | s;
        OP_XOR:  res = d ^ s;
        OP_SHL:  res = d << sh;
        OP_SHRA: res = d >> sh;
        OP_SHRL: res = d >> sh;
        OP_CMP:  begin res = d - s; kind = 2; end
        OP_TST:  res = d & s;
        default: alu = 1'b0;
      endcase
      if (alu) begin
        if (opcode_e'(opc) == OP_SHRA) begin
          k = (sh > 15) ? 32'd15 : sh;
          v = d[15:0] >> k;
          if (d[15]) v = v | 16'(32'hffff << (16 - k));
          m_regs[r1] = v;
        end else if (opcode_e'(opc) != OP_CMP && opcode_e'(opc) != OP_TST) begin
          m_regs[r1] = res[15:0];
        end
        m_flags = '0;
        if (kind == 1 && ((d[15] && s[15] && !res[15]) || (!d[15] && !s[15] && res[15])))
          m_flags[FLAG_O] = 1'b1;
        if (kind == 2 && ((d[15] && !s[15] && !res[15]) || (!d[15] && s[15] && res[15])))
          m_flags[FLAG_O] = 1'b1;
        m_flags[FLAG_C] = res > 32'hffff;
        m_flags[FLAG_Z] = res[15:0] == 16'd0;
        m_flags[FLAG_S] = res[15];
      end else begin
        case (opcode_e'(opc))
          OP_INPUT:   m_regs[r1] = (s < 16) ? {15'd0, c.lines[s[3:0]]} : 16'd0;
          OP_CALL:    begin push_word(m_ip); nip = arg_a; end
          OP_RET:     nip = pop_word() + {8'd0, a} + 16'd4;
          OP_LOAD:    m_regs[r1] = {8'd0, m_mem[s[15:0]]};
          OP_LOADI:   m_regs[r1] = {8'd0, m_mem[arg_b]};
          OP_MOV:     m_regs[r1] = s[15:0];
          OP_MOVI:    m_regs[r1] = arg_b;
          OP_PUSH:    push_word(d[15:0]);
          OP_POP:     m_regs[r1] = pop_word();
          OP_COLOR:   m_color = m_regs[r1][7:0];
          OP_PIXEL:   begin
            r.pv = 1'b1;
            r.px = m_regs[r1];
            r.py = m_regs[r2];
            r.pc = m_color;
          end
          OP_STOR:    m_mem[s[15:0]] = d[7:0];
          OP_STORI:   m_mem[arg_b] = d[7:0];
          OP_TIME:    m_regs[r1] = m_ms;
          OP_TIMERST: m_ms = '0;
          OP_RND:     m_regs[r1] = c.rnd;
          OP_JMP:     nip = m_regs[r1];
          OP_JMPI:    take = 1'b1;
          OP_JEQ:     take = fz;
          OP_JNE:     take = !fz;
          OP_JG:      take = !fz && fs == fo;
          OP_JGE:     take = fs == fo;
          OP_JA:      take = !fc && !fz;
          OP_JAE:     take = !fc;
          OP_JL:      take = fs != fo;
          OP_JLE:     take = fs != fo || fz;
          OP_JB:      take = fc;
          OP_JBE:     take = fc || fz;
          OP_JO:      take = fo;
          OP_JNO:     take = !fo;
          OP_JS:      take = fs;
          OP_JNS:     take = !fs;
          default: ;
        endcase
        if (take) nip = arg_a;
        m_flags = '0;
      end
      m_ip = nip & 16'hfffc;
    end
    r.na = m_ip;
    return r;
  endfunction

  // queue an item and its expected result
  task automatic send(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
    cmd_t c;
    c.op = op;
    c.addr = addr;
    c.data = data;
    c.lines = 16'($urandom);
    c.rnd = 16'($urandom);
    c.hold = 1'b0;
    pending_q.push_back(c);
    expected_q.push_back(core_step(c));
  endtask

  // write an instruction at ip + offset
  task automatic put_instr(int offs, logic [7:0] opc, logic [7:0] a, logic [7:0] b,
                           logic [7:0] c);
    logic [15:0] base;
    base = m_ip + 16'(offs * 4);
    send(ITEM_LOAD, base, opc);
    send(ITEM_LOAD, base + 16'd1, a);
    send(ITEM_LOAD, base + 16'd2, b);
    send(ITEM_LOAD, base + 16'd3, c);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) n_sent <= n_sent + 1;
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() > 0 && pending_q[0].hold && !in_valid_i &&
            n_sent == n_got)
          void'(pending_q.pop_front());
        if (in_gap > 0 || pending_q.size() == 0 || pending_q[0].hold) begin
          if (in_gap > 0) in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else begin
          c = pending_q.pop_front();
          in_valid_i <= 1'b1;
          op_i <= c.op;
          load_address_i <= c.addr;
          load_byte_i <= c.data;
          input_lines_i <= c.lines;
          random_value_i <= c.rnd;
          in_gap <= gap_len();
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_got <= n_got + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result item with none expected, next_address %h", $time,
                   next_address_o);
          n_errors++;
        end else begin
          e = expected_q.pop_front();
          if (pixel_valid_o !== e.pv || pixel_x_o !== e.px || pixel_y_o !== e.py ||
              pixel_color_o !== e.pc || next_address_o !== e.na) begin
            $display("%0t: mismatch exp pv %b x %h y %h col %h ip %h", $time,
                     e.pv, e.px, e.py, e.pc, e.na);
            $display("%0t:          got pv %b x %h y %h col %h ip %h", $time,
                     pixel_valid_o, pixel_x_o, pixel_y_o, pixel_color_o, next_address_o);
            n_errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap <= gap_len();
      end
    end
  end

  initial begin
    cmd_t pause;
    int n_items, n_instr, p;
    logic [7:0] opc;
    foreach (m_regs[i]) m_regs[i] = '0;
    foreach (m_mem[i]) m_mem[i] = '0;
    m_ip = '0;
    m_color = '0;
    m_flags = '0;
    m_ms = '0;
    pause = '{op: ITEM_EXEC, addr: '0, data: '0, lines: '0, rnd: '0, hold: 1'b1};

    // directed: carry and zero, taken jump, divide by zero, saturated
    // arithmetic shift, INPUT past bit 15, pixel, call/return, unknown opcode
    put_instr(0, OP_MOVI, 8'h01, 8'hff, 8'hff);
    put_instr(1, OP_MOVI, 8'h02, 8'h00, 8'h01);
    put_instr(2, OP_ADD, 8'h01, 8'h02, 8'h00);
    put_instr(3, OP_JEQ, 8'h00, 8'h20, 8'h00);
    put_instr(8, OP_DIV, 8'h03, 8'h04, 8'h00);
    put_instr(9, OP_MOVI, 8'h05, 8'h00, 8'h20);
    put_instr(10, OP_SHRA, 8'h03, 8'h05, 8'h00);
    put_instr(11, OP_INPUT, 8'h06, 8'h05, 8'h00);
    put_instr(12, OP_COLOR, 8'h01, 8'h00, 8'h00);
    put_instr(13, OP_PIXEL, 8'h03, 8'h05, 8'h00);
    put_instr(14, OP_CALL, 8'h01, 8'h00, 8'h00);
    put_instr(15, 8'hff, 8'h00, 8'h00, 8'h00);
    send(ITEM_LOAD, 16'h0100, OP_RET);
    send(ITEM_TICK, 16'hffff, 8'hff);
    send(2'd3, 16'h0000, 8'h00);
    repeat (4) send(ITEM_EXEC, '0, '0);
    repeat (5) send(ITEM_EXEC, '0, '0);
    repeat (4) send(ITEM_EXEC, '0, '0);

    // random: short programs written at the current ip, then stepped
    n_items = 0;
    while (n_items < 1500) begin
      if (n_items > 700 && n_items < 760) pending_q.push_back(pause);
      calm = ($urandom_range(0, 9) == 0);
      n_instr = $urandom_range(1, 8);
      for (int i = 0; i < n_instr; i++) begin
        opc = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(45, 255))
                                          : 8'($urandom_range(0, 44));
        put_instr(i, opc, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      n_items += n_instr * 4;
      for (int i = 0; i < n_instr; i++) begin
        p = $urandom_range(0, 19);
        if (p == 0) send(ITEM_TICK, 16'($urandom), 8'($urandom));
        else if (p == 1) send(2'd3, 16'($urandom), 8'($urandom));
        else if (p == 2) send(ITEM_LOAD, 16'($urandom), 8'($urandom));
        send(ITEM_EXEC, 16'($urandom), 8'($urandom));
        n_items += (p < 3) ? 2 : 1;
      end
    end
    gen_done = 1'b1;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (gen_done);
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #8ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### sixteen_bit_cpu_core.f
src/sbcpu_pkg.sv
src/sbcpu_ram.sv
src/sixteen_bit_cpu_core.sv
dv/tb_top.sv
